@@ src/ddm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package ddm_pkg;

    // Field widths
    localparam int SPEED_W    = 14;
    localparam int MIX_W      = 17;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;

    typedef logic signed [SPEED_W-1:0] speed_t;
    typedef logic [CFG_DATA_W-1:0]     gain_t;

    // Register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIXING  = 2'd0,
        CFG_BRAKING = 2'd1,
        CFG_GAIN    = 2'd2
    } cfg_idx_t;

    // Event kinds
    typedef enum logic {
        KIND_SPEED = 1'b0,
        KIND_IDLE  = 1'b1
    } kind_t;

    // Mixer constants
    localparam logic [12:0] DEAD_ZONE  = 13'd37;
    localparam logic [7:0]  DUTY_MAX   = 8'd255;
    localparam speed_t      STEER_LIM  = 14'sd5000;
    localparam speed_t      STEER_NEG  = -14'sd5000;
    localparam gain_t       GAIN_RESET = 6'd16;

    // One motor command beat
    typedef struct packed {
        logic       motor;
        logic [7:0] duty;
        logic       brake;
        logic       forward;
        logic       last;
    } cmd_t;

    // Commands produced by one event
    typedef struct packed {
        logic has_res;
        logic two;
        cmd_t cmd0;
        cmd_t cmd1;
    } res_t;

    // State updates caused by one event
    typedef struct packed {
        logic       steer_we;
        speed_t     steer_val;
        logic [1:0] dir_we;
        logic [1:0] dir_val;
    } upd_t;

endpackage

`default_nettype wire

@@ src/ddm_evt_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface ddm_evt_if;
    import ddm_pkg::*;

    logic   valid;
    logic   ready;
    logic   kind;
    logic   channel;
    speed_t speed;

    modport source (output valid, output kind, output channel, output speed, input ready);
    modport sink   (input valid, input kind, input channel, input speed, output ready);
endinterface

`default_nettype wire

@@ src/ddm_cmd_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface ddm_cmd_if;
    logic       valid;
    logic       ready;
    logic       motor;
    logic [7:0] duty;
    logic       brake;
    logic       forward;
    logic       last;

    modport source (output valid, output motor, output duty, output brake, output forward,
                    output last, input ready);
    modport sink   (input valid, input motor, input duty, input brake, input forward,
                    input last, output ready);
endinterface

`default_nettype wire

@@ src/ddm_mix.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ddm_mix (
    input  wire logic           kind,
    input  wire logic           channel,
    input  wire ddm_pkg::speed_t speed,
    input  wire logic           mix_en,
    input  wire logic           brake_en,
    input  wire ddm_pkg::gain_t gain,
    input  wire ddm_pkg::speed_t steer,
    input  wire logic [1:0]     dir,
    output ddm_pkg::res_t       res,
    output ddm_pkg::upd_t       upd
);
    import ddm_pkg::*;

    logic signed [13:0]      steer_c;
    logic signed [13:0]      steer_b;
    logic signed [10:0]      steer_q;
    logic signed [17:0]      prod;
    logic signed [17:0]      prod_b;
    logic signed [MIX_W-1:0] adj;
    logic signed [MIX_W-1:0] speed_x;
    logic signed [MIX_W-1:0] v_left;
    logic signed [MIX_W-1:0] v_right;

    // Speed to duty, dead zone and brake for one motor
    function automatic cmd_t drive(input logic m, input logic signed [MIX_W-1:0] v,
                                   input logic brk_en, input logic lst);
        logic [MIX_W-1:0] mag;
        logic [12:0]      m16;
        logic [12:0]      amt;
        logic             dz;
        cmd_t             c;
        mag       = v[MIX_W-1] ? MIX_W'(-v) : MIX_W'(v);
        m16       = mag[MIX_W-1:4];
        dz        = (m16 < DEAD_ZONE);
        amt       = m16 - DEAD_ZONE;
        c.motor   = m;
        c.last    = lst;
        c.brake   = dz & brk_en;
        c.duty    = dz ? 8'd0 : ((amt > 13'(DUTY_MAX)) ? DUTY_MAX : amt[7:0]);
        c.forward = c.brake ? 1'b0 : ~v[MIX_W-1];
        return c;
    endfunction

    // Steering term: clamp, /8 toward zero, times gain, /2 toward zero
    always_comb
    begin
        if (steer > STEER_LIM)
            steer_c = STEER_LIM;
        else if (steer < STEER_NEG)
            steer_c = STEER_NEG;
        else
            steer_c = steer;
        steer_b = steer_c + (steer_c[13] ? 14'sd7 : 14'sd0);
        steer_q = steer_b[13:3];
        prod    = steer_q * $signed({1'b0, gain});
        prod_b  = prod + (prod[17] ? 18'sd1 : 18'sd0);
        adj     = prod_b[17:1];
        speed_x = MIX_W'(speed);
        v_left  = speed_x + adj;
        v_right = speed_x - adj;
    end

    // Command selection and state updates
    always_comb
    begin
        res = '0;
        upd = '0;
        if (!mix_en)
        begin
            res.has_res = 1'b1;
            if (kind == KIND_IDLE)
                res.cmd0 = '{motor: channel, duty: 8'd0, brake: 1'b0,
                             forward: dir[channel], last: 1'b1};
            else
            begin
                res.cmd0             = drive(channel, speed_x, brake_en, 1'b1);
                upd.dir_we[channel]  = 1'b1;
                upd.dir_val[channel] = res.cmd0.forward;
            end
        end
        else if (!channel)
        begin
            upd.steer_we  = 1'b1;
            upd.steer_val = (kind == KIND_IDLE) ? '0 : speed;
        end
        else
        begin
            res.has_res = 1'b1;
            res.two     = 1'b1;
            if (kind == KIND_IDLE)
            begin
                res.cmd0 = '{motor: 1'b0, duty: 8'd0, brake: 1'b0, forward: dir[0], last: 1'b0};
                res.cmd1 = '{motor: 1'b1, duty: 8'd0, brake: 1'b0, forward: dir[1], last: 1'b1};
            end
            else
            begin
                res.cmd0    = drive(1'b0, v_left, brake_en, 1'b0);
                res.cmd1    = drive(1'b1, v_right, brake_en, 1'b1);
                upd.dir_we  = 2'b11;
                upd.dir_val = {res.cmd1.forward, res.cmd0.forward};
            end
        end
    end

endmodule

`default_nettype wire

@@ src/ddm_out_buf.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ddm_out_buf (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          load,
    input  wire ddm_pkg::res_t res,
    output logic               free,
    ddm_cmd_if.source          cmd
);
    import ddm_pkg::*;

    logic pend0_reg, pend0_next;
    logic pend1_reg, pend1_next;
    cmd_t c0_reg, c0_next;
    cmd_t c1_reg, c1_next;
    cmd_t cur;
    logic fire;

    // Two command slots, slot 0 goes out first
    assign cur         = pend0_reg ? c0_reg : c1_reg;
    assign cmd.valid   = pend0_reg | pend1_reg;
    assign cmd.motor   = cur.motor;
    assign cmd.duty    = cur.duty;
    assign cmd.brake   = cur.brake;
    assign cmd.forward = cur.forward;
    assign cmd.last    = cur.last;
    assign fire        = cmd.valid & cmd.ready;
    assign free        = ~cmd.valid | (fire & ~(pend0_reg & pend1_reg));

    // Slot bookkeeping
    always_comb
    begin
        pend0_next = pend0_reg;
        pend1_next = pend1_reg;
        c0_next    = c0_reg;
        c1_next    = c1_reg;
        if (load)
        begin
            pend0_next = 1'b1;
            pend1_next = res.two;
            c0_next    = res.cmd0;
            c1_next    = res.cmd1;
        end
        else if (fire)
        begin
            if (pend0_reg)
                pend0_next = 1'b0;
            else
                pend1_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend0_reg <= 1'b0;
            pend1_reg <= 1'b0;
        end
        else
        begin
            pend0_reg <= pend0_next;
            pend1_reg <= pend1_next;
        end
    end

    always_ff @(posedge clk)
    begin
        c0_reg <= c0_next;
        c1_reg <= c1_next;
    end

endmodule

`default_nettype wire

@@ src/differential_drive_mixer_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Differential drive mixer. Takes RC channel events (speed sample or idle
// notice) and emits motor commands with duty, brake and direction. An event
// is registered, mixed combinationally and its commands land in a two-slot
// output register, which takes them once it is empty or sends its last
// pending command; the input stage stalls until then. Commands leave at one
// beat per cycle while the receiver is ready: an unmixed event gives one
// command, a mixed drive event two (left motor, then right motor with last
// set). A steering event under mixing gives no command. Write the
// configuration registers only while no event is in flight.
module differential_drive_mixer_unit (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    ddm_evt_if.sink                               rc_evt,
    ddm_cmd_if.source                             motor_cmd,
    input  wire logic                             cfg_we,
    input  wire logic [ddm_pkg::CFG_IDX_W-1:0]    cfg_idx,
    input  wire logic [ddm_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import ddm_pkg::*;

    logic       mix_en_reg, mix_en_next;
    logic       brk_en_reg, brk_en_next;
    gain_t      gain_reg, gain_next;
    logic       a_valid_reg, a_valid_next;
    logic       a_kind_reg;
    logic       a_chan_reg;
    speed_t     a_speed_reg;
    speed_t     steer_reg, steer_next;
    logic [1:0] dir_reg, dir_next;

    res_t res;
    upd_t upd;
    logic free;
    logic advance;
    logic in_fire;

    // Configuration registers
    always_comb
    begin
        mix_en_next = mix_en_reg;
        brk_en_next = brk_en_reg;
        gain_next   = gain_reg;
        if (cfg_we)
        begin
            case (cfg_idx)
                CFG_MIXING:  mix_en_next = cfg_data[0];
                CFG_BRAKING: brk_en_next = cfg_data[0];
                CFG_GAIN:    gain_next   = cfg_data;
                default:     ;
            endcase
        end
    end

    // Input stage handshake
    assign advance      = a_valid_reg & (~res.has_res | free);
    assign rc_evt.ready = ~a_valid_reg | advance;
    assign in_fire      = rc_evt.valid & rc_evt.ready;
    assign a_valid_next = in_fire | (a_valid_reg & ~advance);

    ddm_mix u_mix (
        .kind     (a_kind_reg),
        .channel  (a_chan_reg),
        .speed    (a_speed_reg),
        .mix_en   (mix_en_reg),
        .brake_en (brk_en_reg),
        .gain     (gain_reg),
        .steer    (steer_reg),
        .dir      (dir_reg),
        .res      (res),
        .upd      (upd)
    );

    ddm_out_buf u_out (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (advance & res.has_res),
        .res   (res),
        .free  (free),
        .cmd   (motor_cmd)
    );

    // Steering and direction state
    always_comb
    begin
        steer_next = steer_reg;
        dir_next   = dir_reg;
        if (advance)
        begin
            if (upd.steer_we)
                steer_next = upd.steer_val;
            if (upd.dir_we[0])
                dir_next[0] = upd.dir_val[0];
            if (upd.dir_we[1])
                dir_next[1] = upd.dir_val[1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mix_en_reg  <= 1'b0;
            brk_en_reg  <= 1'b0;
            gain_reg    <= GAIN_RESET;
            a_valid_reg <= 1'b0;
            steer_reg   <= '0;
            dir_reg     <= 2'b00;
        end
        else
        begin
            mix_en_reg  <= mix_en_next;
            brk_en_reg  <= brk_en_next;
            gain_reg    <= gain_next;
            a_valid_reg <= a_valid_next;
            steer_reg   <= steer_next;
            dir_reg     <= dir_next;
        end
    end

    // Event payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            a_kind_reg  <= rc_evt.kind;
            a_chan_reg  <= rc_evt.channel;
            a_speed_reg <= rc_evt.speed;
        end
    end

endmodule

`default_nettype wire

@@ src/ddm_chk.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ddm_chk (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       cmd_valid,
    input wire logic       cmd_ready,
    input wire logic       cmd_motor,
    input wire logic [7:0] cmd_duty,
    input wire logic       cmd_brake,
    input wire logic       cmd_forward,
    input wire logic       cmd_last
);

    // A braking motor has no drive and is marked reverse
    a_brake_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_brake |-> cmd_duty == 8'd0 && !cmd_forward)
        else $error("brake with drive or forward set");

    // Only the left command of a pair is not last
    a_pair_left: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_last |-> !cmd_motor)
        else $error("non-final command not for left motor");

    // The right command follows straight after the left one of a pair
    a_pair_next: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready && !cmd_last |=> cmd_valid && cmd_motor && cmd_last)
        else $error("right command missing after left");

    // A stalled beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_ready |=> cmd_valid && $stable(cmd_motor) && $stable(cmd_duty)
            && $stable(cmd_brake) && $stable(cmd_forward) && $stable(cmd_last))
        else $error("stalled command changed");

endmodule

bind differential_drive_mixer_unit ddm_chk u_ddm_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_valid   (motor_cmd.valid),
    .cmd_ready   (motor_cmd.ready),
    .cmd_motor   (motor_cmd.motor),
    .cmd_duty    (motor_cmd.duty),
    .cmd_brake   (motor_cmd.brake),
    .cmd_forward (motor_cmd.forward),
    .cmd_last    (motor_cmd.last)
);

`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import ddm_pkg::*;

    localparam int  CLK_HALF     = 4;
    localparam int  RESET_CYCLES = 9;
    localparam int  SETTLE_WAIT  = 8;
    localparam int  TAIL_WAIT    = 10;
    localparam int  HOLD_CYCLES  = 300;
    localparam int  LIMIT_CYCLES = 200000;
    localparam bit  CH_STEER     = 1'b0;
    localparam bit  CH_DRIVE     = 1'b1;
    localparam bit  MOTOR_LEFT   = 1'b0;
    localparam bit  MOTOR_RIGHT  = 1'b1;

    logic clk;
    logic rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    ddm_evt_if rc_bus ();
    ddm_cmd_if cmd_bus ();

    differential_drive_mixer_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .rc_evt    (rc_bus),
        .motor_cmd (cmd_bus),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_data  (cfg_data)
    );

    // Mirror of the mixer state and its register file
    bit    mix_on;
    bit    brake_on;
    gain_t steer_gain;
    int    steer_store;
    bit    dir_state [2];

    cmd_t  pending_cmds [$];
    int    err_count;
    int    cycle_count;
    int    src_idle_pct;
    int    sink_idle_pct;
    bit    hold_off;
    bit    evt_hot;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("testbench: errors");
            $finish;
        end
    end

    // Command for one motor at a given signed level
    function automatic cmd_t motor_command(bit m, int level, bit last_flag);
        cmd_t c;
        int   mag;
        int   amt;
        mag = (level < 0) ? -level : level;
        amt = mag / 16 - int'(DEAD_ZONE);
        c.motor = m;
        c.last  = last_flag;
        if (amt < 0 && brake_on)
        begin
            dir_state[m] = 1'b0;
            c.duty  = 8'd0;
            c.brake = 1'b1;
        end
        else
        begin
            dir_state[m] = (level >= 0);
            if (amt > int'(DUTY_MAX))
                amt = int'(DUTY_MAX);
            if (amt < 0)
                amt = 0;
            c.duty  = amt[7:0];
            c.brake = 1'b0;
        end
        c.forward = dir_state[m];
        return c;
    endfunction

    // Idle notice: coast, direction kept
    function automatic cmd_t idle_command(bit m, bit last_flag);
        cmd_t c;
        c.motor   = m;
        c.duty    = 8'd0;
        c.brake   = 1'b0;
        c.forward = dir_state[m];
        c.last    = last_flag;
        return c;
    endfunction

    // Expected commands for one accepted event
    function automatic void predict_commands(kind_t k, bit ch, speed_t spd);
        int sp;
        int s;
        sp = spd;
        if (!mix_on)
        begin
            if (k == KIND_IDLE)
                pending_cmds.push_back(idle_command(ch, 1'b1));
            else
                pending_cmds.push_back(motor_command(ch, sp, 1'b1));
            return;
        end
        if (ch == CH_STEER)
        begin
            steer_store = (k == KIND_IDLE) ? 0 : sp;
            return;
        end
        if (k == KIND_IDLE)
        begin
            pending_cmds.push_back(idle_command(MOTOR_LEFT, 1'b0));
            pending_cmds.push_back(idle_command(MOTOR_RIGHT, 1'b1));
            return;
        end
        s = steer_store;
        if (s > int'(STEER_LIM))
            s = int'(STEER_LIM);
        if (s < int'(STEER_NEG))
            s = int'(STEER_NEG);
        s = ((s / 8) * int'(steer_gain)) / 2;
        pending_cmds.push_back(motor_command(MOTOR_LEFT, sp + s, 1'b0));
        pending_cmds.push_back(motor_command(MOTOR_RIGHT, sp - s, 1'b1));
    endfunction

    // Command sink: check each beat, then pick the next ready
    always @(posedge clk)
    begin : cmd_sink
        cmd_t want;
        if (rst_n)
        begin
            if (cmd_bus.valid && cmd_bus.ready)
            begin
                if (pending_cmds.size() == 0)
                begin
                    $error("unexpected beat: motor %0d duty %0d brake %0d",
                           cmd_bus.motor, cmd_bus.duty, cmd_bus.brake);
                    err_count++;
                end
                else
                begin
                    want = pending_cmds.pop_front();
                    if (cmd_bus.motor !== want.motor)
                    begin
                        $error("motor: expected %0d, got %0d", want.motor, cmd_bus.motor);
                        err_count++;
                    end
                    if (cmd_bus.duty !== want.duty)
                    begin
                        $error("duty: expected %0d, got %0d", want.duty, cmd_bus.duty);
                        err_count++;
                    end
                    if (cmd_bus.brake !== want.brake)
                    begin
                        $error("brake: expected %0d, got %0d", want.brake, cmd_bus.brake);
                        err_count++;
                    end
                    if (cmd_bus.forward !== want.forward)
                    begin
                        $error("forward: expected %0d, got %0d",
                               want.forward, cmd_bus.forward);
                        err_count++;
                    end
                    if (cmd_bus.last !== want.last)
                    begin
                        $error("last: expected %0d, got %0d", want.last, cmd_bus.last);
                        err_count++;
                    end
                end
            end
            cmd_bus.ready <= !hold_off && ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // One event beat; valid stays up so back-to-back beats need no gap
    task automatic send_event(kind_t k, bit ch, speed_t spd);
        int gap;
        gap = 0;
        while ($urandom_range(99) < src_idle_pct)
            gap++;
        if (gap > 0)
        begin
            if (evt_hot)
                rc_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rc_bus.valid   <= 1'b1;
        rc_bus.kind    <= k;
        rc_bus.channel <= ch;
        rc_bus.speed   <= spd;
        evt_hot = 1'b1;
        do
            @(posedge clk);
        while (!rc_bus.ready);
        predict_commands(k, ch, spd);
    endtask

    task automatic release_events();
        if (evt_hot)
            rc_bus.valid <= 1'b0;
        evt_hot = 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_cmds.size() != 0)
            @(posedge clk);
    endtask

    // Idle point: nothing in flight, including steering beats with no command
    task automatic settle();
        release_events();
        wait_drained();
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    // Write all three registers on consecutive cycles
    task automatic write_config(bit mix, bit brk, gain_t gain);
        settle();
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_MIXING;
        cfg_data <= gain_t'(mix);
        @(posedge clk);
        cfg_idx  <= CFG_BRAKING;
        cfg_data <= gain_t'(brk);
        @(posedge clk);
        cfg_idx  <= CFG_GAIN;
        cfg_data <= gain;
        @(posedge clk);
        cfg_we   <= 1'b0;
        mix_on     = mix;
        brake_on   = brk;
        steer_gain = gain;
    endtask

    function automatic speed_t pick_speed();
        int v;
        case ($urandom_range(5))
            0: v = int'(speed_t'($urandom));
            1: v = $urandom_range(16000) - 8000;
            2: v = $urandom_range(640, 560);
            3: v = $urandom_range(4720, 4600);
            4: v = $urandom_range(100);
            default:
            begin
                case ($urandom_range(5))
                    0: v = 8191;
                    1: v = -8192;
                    2: v = 8000;
                    3: v = -8000;
                    4: v = 5000;
                    default: v = 5001;
                endcase
            end
        endcase
        if ($urandom_range(1) && v > 0)
            v = -v;
        return speed_t'(v);
    endfunction

    function automatic gain_t pick_gain();
        case ($urandom_range(3))
            0: return gain_t'(0);
            1: return gain_t'(52);
            2: return gain_t'(63);
            default: return gain_t'($urandom_range(63));
        endcase
    endfunction

    // Extremes of the fields, dead zone edges and saturation, reset settings
    task automatic test_unmixed_directed();
        send_event(KIND_SPEED, 1'b0, 14'sd0);
        send_event(KIND_SPEED, 1'b1, -14'sd1);
        send_event(KIND_SPEED, 1'b0, 14'sd607);
        send_event(KIND_SPEED, 1'b1, 14'sd608);
        send_event(KIND_SPEED, 1'b0, 14'sd4672);
        send_event(KIND_SPEED, 1'b1, 14'sd4688);
        send_event(KIND_SPEED, 1'b0, 14'sd8191);
        send_event(KIND_SPEED, 1'b1, speed_t'(-8192));
        send_event(KIND_IDLE, 1'b1, speed_t'($urandom));
        // braking inside the dead zone, then idle keeps the cleared direction
        write_config(1'b0, 1'b1, GAIN_RESET);
        send_event(KIND_SPEED, 1'b0, -14'sd100);
        send_event(KIND_IDLE, 1'b0, speed_t'($urandom));
        send_event(KIND_SPEED, 1'b1, 14'sd608);
    endtask

    // Steering store, clamp, both gain extremes and idle on each channel
    task automatic test_mixed_directed();
        write_config(1'b1, 1'b1, gain_t'(52));
        send_event(KIND_SPEED, CH_STEER, 14'sd8191);
        send_event(KIND_SPEED, CH_DRIVE, 14'sd1000);
        send_event(KIND_SPEED, CH_STEER, speed_t'(-8192));
        send_event(KIND_SPEED, CH_DRIVE, -14'sd8000);
        send_event(KIND_IDLE, CH_DRIVE, 14'sd0);
        send_event(KIND_IDLE, CH_STEER, 14'sd0);
        send_event(KIND_SPEED, CH_DRIVE, 14'sd0);
        write_config(1'b1, 1'b0, gain_t'(63));
        send_event(KIND_SPEED, CH_STEER, 14'sd5000);
        send_event(KIND_SPEED, CH_DRIVE, 14'sd8191);
        write_config(1'b1, 1'b0, gain_t'(0));
        send_event(KIND_SPEED, CH_DRIVE, -14'sd5000);
    endtask

    // Random traffic under changing settings
    task automatic test_random_traffic(int src_pct, int sink_pct, int n_items);
        int left;
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        left = n_items;
        while (left > 0)
        begin
            write_config($urandom_range(3) != 0, 1'($urandom_range(1)), pick_gain());
            repeat ($urandom_range(60, 40))
            begin
                if (left > 0)
                begin
                    send_event(($urandom_range(99) < 15) ? KIND_IDLE : KIND_SPEED,
                               1'($urandom_range(1)), pick_speed());
                    left--;
                end
            end
        end
    endtask

    // Long receiver hold-off to fill the block, then a full sender pause
    task automatic test_backpressure();
        write_config(1'b1, 1'($urandom_range(1)), pick_gain());
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        fork
            begin
                hold_off <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_off <= 1'b0;
            end
        join_none
        for (int i = 0; i < 40; i++)
            send_event(KIND_SPEED, i[0], pick_speed());
        release_events();
        wait_drained();
        @(posedge clk);
        for (int i = 0; i < 10; i++)
            send_event(KIND_SPEED, i[0], pick_speed());
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_idx        = CFG_MIXING;
        cfg_data       = '0;
        rc_bus.valid   = 1'b0;
        rc_bus.kind    = KIND_SPEED;
        rc_bus.channel = 1'b0;
        rc_bus.speed   = '0;
        cmd_bus.ready  = 1'b0;
        hold_off       = 1'b0;
        evt_hot        = 1'b0;
        err_count      = 0;
        cycle_count    = 0;
        src_idle_pct   = 0;
        sink_idle_pct  = 0;
        mix_on         = 1'b0;
        brake_on       = 1'b0;
        steer_gain     = GAIN_RESET;
        steer_store    = 0;
        dir_state[0]   = 1'b0;
        dir_state[1]   = 1'b0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_unmixed_directed();
        test_mixed_directed();
        test_random_traffic(32, 70, 260);
        test_random_traffic(70, 32, 260);
        test_random_traffic(0, 0, 260);
        test_backpressure();

        release_events();
        wait_drained();
        repeat (TAIL_WAIT) @(posedge clk);
        if (err_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

@@ sim.f @@
src/ddm_pkg.sv
src/ddm_evt_if.sv
src/ddm_cmd_if.sv
src/ddm_mix.sv
src/ddm_out_buf.sv
src/differential_drive_mixer_unit.sv
src/ddm_chk.sv
tb/testbench.sv
